// ===== design/mf_pkg.sv =====
`default_nettype none

package mf_pkg;

	// Elaboration defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Configuration registers
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// Input row counter runs up to two rows past the image while draining
	localparam int ROW_BITS = HEIGHT_REG_BITS + 1;

	// 3x3 window, row-major, newest column on the right
	localparam int WIN_TAPS   = 9;
	localparam int WIN_CENTER = 4;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Per-beat control that travels with a pixel from front to output
	typedef struct packed {
		logic emit;    // this beat produces an output pixel
		logic median;  // output pixel is interior: take the median
		logic last;    // output pixel closes the frame
	} mf_ctl_t;

endpackage

`default_nettype wire

// ===== design/mf_front.sv =====
`default_nettype none

module mf_front #(
	parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [PIXEL_BITS-1:0]                pixel_in,
	input  logic                                 flush,
	input  logic                                 cfg_write,
	input  logic [mf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [mf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                 q_full,
	output logic                                 push,
	output logic [PIXEL_BITS-1:0]                push_pix,
	output logic [$clog2(MAX_WIDTH)-1:0]         push_col,
	output mf_pkg::mf_ctl_t                      push_ctl
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int WW1 = WW + 1;
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int RW  = mf_pkg::ROW_BITS;
	localparam int HW  = mf_pkg::HEIGHT_REG_BITS;
	localparam int RB  = mf_pkg::WIDTH_REG_BITS;
	localparam int CW  = (WW > RB) ? WW : RB;

	// zero acts as one, anything above the line store depth as the depth
	function automatic logic [WW-1:0] clamp_width(input logic [RB-1:0] raw);
		logic [CW-1:0] ext;
		ext = CW'(raw);
		if (raw == '0) begin
			return WW'(1);
		end else if (ext > CW'(MAX_WIDTH)) begin
			return WW'(MAX_WIDTH);
		end else begin
			return WW'(raw);
		end
	endfunction

	function automatic logic [HW-1:0] clamp_height(input logic [HW-1:0] raw);
		return (raw == '0) ? HW'(1) : raw;
	endfunction

	localparam logic [WW-1:0] WIDTH_INIT  = clamp_width(RB'(mf_pkg::WIDTH_RESET));
	localparam logic [HW-1:0] HEIGHT_INIT = HW'(mf_pkg::HEIGHT_RESET);

	logic [WW-1:0]  width_q;
	logic [HW-1:0]  height_q;
	logic [XW-1:0]  in_col_q;
	logic [RW-1:0]  in_row_q;
	logic [XW-1:0]  out_col_q;
	logic [HW-1:0]  out_row_q;

	logic           accept;
	logic           draining;
	logic           due;
	logic           in_wrap;
	logic           out_wrap;
	logic           is_last;
	logic           interior;
	logic [WW-1:0]  in_col_nx;
	logic [WW-1:0]  out_col_nx;
	logic [RW-1:0]  out_row_nx;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// past the last image row the beats drain the remaining outputs
	assign draining = in_row_q >= RW'(height_q);
	assign push     = accept && !(flush && !draining);

	assign due = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));

	assign in_col_nx  = WW'(in_col_q) + WW'(1);
	assign in_wrap    = in_col_nx == width_q;
	assign out_col_nx = WW'(out_col_q) + WW'(1);
	assign out_wrap   = out_col_nx == width_q;
	assign out_row_nx = RW'(out_row_q) + RW'(1);
	assign is_last    = out_wrap && (out_row_nx >= RW'(height_q));

	assign interior = (out_row_q != '0) && (RW'(out_row_q) + RW'(2) <= RW'(height_q))
		&& (out_col_q != '0) && (WW1'(out_col_q) + WW1'(2) <= WW1'(width_q));

	assign push_pix = draining ? '0 : pixel_in;
	assign push_col = in_col_q;
	assign push_ctl = '{emit: due, median: interior, last: is_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_INIT;
			height_q  <= HEIGHT_INIT;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mf_pkg::REG_IMAGE_WIDTH: begin
					width_q <= clamp_width(cfg_data[RB-1:0]);
				end
				mf_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= clamp_height(cfg_data[HW-1:0]);
				end
			endcase
			// any register write restarts the frame
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (push) begin
			if (due && is_last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_wrap ? '0 : in_col_nx[XW-1:0];
				if (in_wrap) begin
					in_row_q <= in_row_q + RW'(1);
				end
				if (due) begin
					out_col_q <= out_wrap ? '0 : out_col_nx[XW-1:0];
					if (out_wrap) begin
						out_row_q <= out_row_nx[HW-1:0];
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/mf_queue.sv =====
`default_nettype none

module mf_queue #(
	parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF,
	parameter int COL_BITS   = $clog2(mf_pkg::MAX_WIDTH_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [PIXEL_BITS-1:0] push_pix,
	input  logic [COL_BITS-1:0]   push_col,
	input  mf_pkg::mf_ctl_t       push_ctl,
	output logic                  full,
	input  logic                  pop,
	output logic                  q_valid,
	output logic [PIXEL_BITS-1:0] q_pix,
	output logic [COL_BITS-1:0]   q_col,
	output mf_pkg::mf_ctl_t       q_ctl
);

	localparam int DEPTH = mf_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNW   = $clog2(DEPTH + 1);

	logic [PIXEL_BITS-1:0] pix_q [DEPTH];
	logic [COL_BITS-1:0]   col_q [DEPTH];
	mf_pkg::mf_ctl_t       ctl_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CNW-1:0]        count_q;

	assign full    = count_q == CNW'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_pix   = pix_q[rd_ptr_q];
	assign q_col   = col_q[rd_ptr_q];
	assign q_ctl   = ctl_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNW'(1);
				2'b01:   count_q <= count_q - CNW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pix_q[wr_ptr_q] <= push_pix;
			col_q[wr_ptr_q] <= push_col;
			ctl_q[wr_ptr_q] <= push_ctl;
		end
	end

endmodule

`default_nettype wire

// ===== design/mf_back.sv =====
`default_nettype none

module mf_back #(
	parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              q_valid,
	output logic                                              pop,
	input  logic [PIXEL_BITS-1:0]                             q_pix,
	input  logic [$clog2(MAX_WIDTH)-1:0]                      q_col,
	input  mf_pkg::mf_ctl_t                                   q_ctl,
	output logic                                              win_valid,
	input  logic                                              win_ready,
	output logic [mf_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]       win,
	output mf_pkg::mf_ctl_t                                   win_ctl
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int PB = PIXEL_BITS;
	localparam int NT = mf_pkg::WIN_TAPS;

	// one entry per column: {two rows up, one row up}
	logic [2*PB-1:0] line_mem [MAX_WIDTH];

	logic                 v_s1;
	logic                 fwd_s1;
	logic [PB-1:0]        pix_s1;
	logic [XW-1:0]        col_s1;
	mf_pkg::mf_ctl_t      ctl_s1;
	logic [2*PB-1:0]      rd_s1;
	logic [2*PB-1:0]      fwd_data_s1;

	logic                 v_s2;
	logic [NT-1:0][PB-1:0] win_s2;
	mf_pkg::mf_ctl_t      ctl_s2;

	logic [NT-1:0][PB-1:0] win_q;
	logic [NT-1:0][PB-1:0] win_nx;

	logic [2*PB-1:0]      entry;
	logic [2*PB-1:0]      wr_data;
	logic                 s1_ready;
	logic                 s2_ready;
	logic                 fire1;

	// read issued in the cycle the previous beat writes the same column
	// returns old data, so take the write data instead
	assign entry   = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_data = {entry[PB-1:0], pix_s1};

	assign s2_ready = !v_s2 || win_ready;
	assign fire1    = v_s1 && (!ctl_s1.emit || s2_ready);
	assign s1_ready = !v_s1 || fire1;
	assign pop      = q_valid && s1_ready;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r*3]     = win_q[r*3 + 1];
			win_nx[r*3 + 1] = win_q[r*3 + 2];
		end
		win_nx[2] = entry[2*PB-1:PB];
		win_nx[5] = entry[PB-1:0];
		win_nx[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= q_valid;
			end
			if (pop) begin
				fwd_s1 <= fire1 && (col_s1 == q_col);
			end
			if (fire1 && ctl_s1.emit) begin
				v_s2 <= 1'b1;
			end else if (win_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_s1      <= q_pix;
			col_s1      <= q_col;
			ctl_s1      <= q_ctl;
			fwd_data_s1 <= wr_data;
		end
		if (fire1) begin
			win_q <= win_nx;
		end
		if (fire1 && ctl_s1.emit) begin
			win_s2 <= win_nx;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			line_mem[col_s1] <= wr_data;
		end
		if (pop) begin
			rd_s1 <= line_mem[q_col];
		end
	end

	assign win_valid = v_s2;
	assign win       = win_s2;
	assign win_ctl   = ctl_s2;

endmodule

`default_nettype wire

// ===== design/mf_sort.sv =====
`default_nettype none

module mf_sort #(
	parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        win_valid,
	output logic                                        win_ready,
	input  logic [mf_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] win,
	input  mf_pkg::mf_ctl_t                             win_ctl,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [PIXEL_BITS-1:0]                       pixel_out,
	output logic                                        last_pixel
);

	localparam int PB = PIXEL_BITS;

	function automatic logic [PB-1:0] min2(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PB-1:0] max2(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
		input logic [PB-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	logic [2:0][PB-1:0] col_lo;
	logic [2:0][PB-1:0] col_mid;
	logic [2:0][PB-1:0] col_hi;

	logic               v_s3;
	logic [2:0][PB-1:0] lo_s3;
	logic [2:0][PB-1:0] mid_s3;
	logic [2:0][PB-1:0] hi_s3;
	logic [PB-1:0]      center_s3;
	mf_pkg::mf_ctl_t    ctl_s3;

	logic               v_s4;
	logic [PB-1:0]      max_lo_s4;
	logic [PB-1:0]      med_mid_s4;
	logic [PB-1:0]      min_hi_s4;
	logic [PB-1:0]      center_s4;
	mf_pkg::mf_ctl_t    ctl_s4;

	logic               v_s5;
	logic [PB-1:0]      pix_s5;
	logic               last_s5;

	logic               rdy_s4;
	logic               rdy_s5;

	// sort each column; median of nine is then the median of
	// (largest low, middle mid, smallest high)
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			col_lo[c]  = min2(min2(win[c], win[c + 3]), win[c + 6]);
			col_mid[c] = med3(win[c], win[c + 3], win[c + 6]);
			col_hi[c]  = max2(max2(win[c], win[c + 3]), win[c + 6]);
		end
	end

	assign rdy_s5    = !v_s5 || out_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign win_ready = !v_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (win_ready) begin
				v_s3 <= win_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_ready && win_valid) begin
			lo_s3     <= col_lo;
			mid_s3    <= col_mid;
			hi_s3     <= col_hi;
			center_s3 <= win[mf_pkg::WIN_CENTER];
			ctl_s3    <= win_ctl;
		end
		if (rdy_s4 && v_s3) begin
			max_lo_s4  <= max2(max2(lo_s3[0], lo_s3[1]), lo_s3[2]);
			med_mid_s4 <= med3(mid_s3[0], mid_s3[1], mid_s3[2]);
			min_hi_s4  <= min2(min2(hi_s3[0], hi_s3[1]), hi_s3[2]);
			center_s4  <= center_s3;
			ctl_s4     <= ctl_s3;
		end
		if (rdy_s5 && v_s4) begin
			pix_s5  <= ctl_s4.median ? med3(max_lo_s4, med_mid_s4, min_hi_s4) : center_s4;
			last_s5 <= ctl_s4.last;
		end
	end

	assign out_valid  = v_s5;
	assign pixel_out  = pix_s5;
	assign last_pixel = last_s5;

endmodule

`default_nettype wire

// ===== design/median_filter_3x3.sv =====
`default_nettype none

// Channel   Handshake                     Payload
// --------  ----------------------------  ------------------------------------
// input     in_valid / in_ready           pixel_in[PIXEL_BITS], flush
// output    out_valid / out_ready         pixel_out[PIXEL_BITS], last_pixel
// config    cfg_write (no wait)           cfg_index (0 width, 1 height), cfg_data
//
// Sustains one input beat per clock while the queue is not full; the line store
// takes one read and one write per cycle, and the median network is a fixed
// three-stage pipe.
// Reset clears counters, queue and pipeline valids; line store and window are
// not cleared, since every pixel that reaches an output is written in the frame.
// in_ready drops only when the 4-entry queue fills, i.e. after the output side
// has stalled; it never depends on out_ready in the same cycle.

module median_filter_3x3 #(
	parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PIXEL_BITS-1:0]             pixel_in,
	input  logic                              flush,
	// filtered output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [PIXEL_BITS-1:0]             pixel_out,
	output logic                              last_pixel,
	// register writes
	input  logic                              cfg_write,
	input  logic [mf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);

	// front -> queue
	logic                  push;
	logic [PIXEL_BITS-1:0] push_pix;
	logic [XW-1:0]         push_col;
	mf_pkg::mf_ctl_t       push_ctl;
	logic                  q_full;

	// queue -> back
	logic                  q_valid;
	logic                  pop;
	logic [PIXEL_BITS-1:0] q_pix;
	logic [XW-1:0]         q_col;
	mf_pkg::mf_ctl_t       q_ctl;

	// back -> median pipe
	logic                                        win_valid;
	logic                                        win_ready;
	logic [mf_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] win;
	mf_pkg::mf_ctl_t                             win_ctl;

	// Front: register file, raster counters, drops flush beats that arrive
	// mid-frame, zeroes drained pixels and tags each beat with its output role.
	mf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.flush     (flush),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_pix  (push_pix),
		.push_col  (push_col),
		.push_ctl  (push_ctl)
	);

	// Short queue so the front keeps taking beats while the back is stalled
	mf_queue #(
		.PIXEL_BITS (PIXEL_BITS),
		.COL_BITS   (XW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pix (push_pix),
		.push_col (push_col),
		.push_ctl (push_ctl),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_pix    (q_pix),
		.q_col    (q_col),
		.q_ctl    (q_ctl)
	);

	// Back: line store (two rows per column word) with write forwarding,
	// 3x3 window shift, snapshot of the window for beats that emit.
	mf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (pop),
		.q_pix     (q_pix),
		.q_col     (q_col),
		.q_ctl     (q_ctl),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.win_ctl   (win_ctl)
	);

	// Median network: column sort, cross-column select, final med3 / border
	// pass-through into the output register.
	mf_sort #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_sort (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (win_valid),
		.win_ready  (win_ready),
		.win        (win),
		.win_ctl    (win_ctl),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.last_pixel (last_pixel)
	);

endmodule

`default_nettype wire

// ===== design/mf_checker.sv =====
`default_nettype none

module mf_checker #(
	parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [PIXEL_BITS-1:0] pixel_out,
	input logic                  last_pixel
);

	// a stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_pixel))
		else $error("output beat changed while stalled");

	// a ready sink frees a queue slot, so in_ready is high in the next cycle
	a_ready_recovers: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |=> in_ready)
		else $error("in_ready low after out_ready cycle");

	// the queue only fills behind a stalled output
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready dropped without output stall");

endmodule

bind median_filter_3x3 mf_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_mf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pixel_out  (pixel_out),
	.last_pixel (last_pixel)
);

`default_nettype wire
